/* src/assert_macros.svh */
// Assertion macros shared by the YMODEM receiver modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that an expression never holds outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

/* src/ymr_pkg.sv */
// Types, codes and the CRC-16 byte update shared by the YMODEM receiver.
`default_nettype none

package ymr_pkg;

   localparam int POS_W      = 11;
   localparam int SIZE_W     = 24;
   localparam int CSR_ADDR_W = 3;

   localparam logic [7:0] SOH_CODE = 8'h01;
   localparam logic [7:0] STX_CODE = 8'h02;
   localparam logic [7:0] CAN_CODE = 8'h18;
   localparam logic [7:0] DIGIT_LO = 8'h30;
   localparam logic [7:0] DIGIT_HI = 8'h39;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [2:0] CANCEL_RUN_LEN = 3'd5;
   localparam logic [7:0] ACK_RESET = 8'h06;

   // Register index decoded from the byte address.
   localparam logic REG_ACK_CODE = 1'b0;

   localparam logic [2:0] ST_NONE   = 3'd0;
   localparam logic [2:0] ST_HEADER = 3'd1;
   localparam logic [2:0] ST_DATA   = 3'd2;
   localparam logic [2:0] ST_CANCEL = 3'd3;
   localparam logic [2:0] ST_REJECT = 3'd4;

   localparam logic [1:0] NAME_IN_NAME = 2'd0;
   localparam logic [1:0] NAME_IN_SIZE = 2'd1;
   localparam logic [1:0] NAME_DONE    = 2'd2;

   typedef enum logic {
      PH_HEADER = 1'b0,
      PH_DATA   = 1'b1
   } phase_type;

   typedef struct packed {
      logic              payload_valid;
      logic [7:0]        payload_byte;
      logic              frame_done;
      logic [2:0]        frame_status;
      logic              send_ack;
      logic              transfer_done;
      logic [SIZE_W-1:0] announced_size;
      logic [SIZE_W-1:0] received_bytes;
   } rsp_type;

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

`default_nettype wire

/* src/ymodem_block_receiver.sv */
// Top level of the YMODEM block receiver: input stage, checker core, result stage, registers.
//
//   Channel   Direction   Transfer when          Carries
//   req_      in          req_valid & !req_stall  rx_byte, frame_last
//   rsp_      out         rsp_valid & !rsp_stall  payload, verdict, size, byte count
//   csr_      in/out      psel & penable & pwrite ack_code at byte address 0
//
// One byte is taken every cycle unless the result side stalls; each byte gives one result.
// The byte goes into an input register, the core checks it combinationally and updates
// the frame state, and the result waits in an output register until it is transferred.
// Reset is synchronous and clears the frame state; ack_code returns to 0x06.
// A stalled result holds both stages; the input stage still takes one byte behind it.
`default_nettype none
`include "assert_macros.svh"

module ymodem_block_receiver #(
   parameter int DATA_BLOCK_BYTES   = 1024,
   parameter int HEADER_BLOCK_BYTES = 128,
   parameter int SIZE_DIGITS        = 7
) (
   input  wire logic                           clock,
   input  wire logic                           reset,

   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [7:0]                     req_rx_byte,
   input  wire logic                           req_frame_last,

   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_payload_valid,
   output logic      [7:0]                     rsp_payload_byte,
   output logic                                rsp_frame_done,
   output logic      [2:0]                     rsp_frame_status,
   output logic                                rsp_send_ack,
   output logic                                rsp_transfer_done,
   output logic      [ymr_pkg::SIZE_W-1:0]     rsp_announced_size,
   output logic      [ymr_pkg::SIZE_W-1:0]     rsp_received_bytes,

   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [ymr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                    csr_pwdata,
   output logic      [31:0]                    csr_prdata,
   output logic                                csr_pready
);

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff;
   logic             in_last_ff;
   logic             out_valid_ff, out_valid_in;
   ymr_pkg::rsp_type out_ff;
   ymr_pkg::rsp_type core_result;
   logic             out_free;
   logic             step;
   logic             req_take;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_free ? step : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_rx_byte;
         in_last_ff <= req_frame_last;
      end
      if (step) begin
         out_ff <= core_result;
      end
   end

   ymr_core #(
      .DATA_BLOCK_BYTES   (DATA_BLOCK_BYTES),
      .HEADER_BLOCK_BYTES (HEADER_BLOCK_BYTES),
      .SIZE_DIGITS        (SIZE_DIGITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .rx_byte    (in_byte_ff),
      .frame_last (in_last_ff),
      .result     (core_result)
   );

   ymr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   assign rsp_valid          = out_valid_ff;
   assign rsp_payload_valid  = out_ff.payload_valid;
   assign rsp_payload_byte   = out_ff.payload_byte;
   assign rsp_frame_done     = out_ff.frame_done;
   assign rsp_frame_status   = out_ff.frame_status;
   assign rsp_send_ack       = out_ff.send_ack;
   assign rsp_transfer_done  = out_ff.transfer_done;
   assign rsp_announced_size = out_ff.announced_size;
   assign rsp_received_bytes = out_ff.received_bytes;

   `ASSERT_PROP(a_stall_means_full, clock, reset, req_stall |-> out_valid_ff && rsp_stall, "input stalled while the result stage can move")
   `ASSERT_PROP(a_done_on_accept, clock, reset, out_valid_ff && out_ff.transfer_done |-> out_ff.frame_status == ymr_pkg::ST_HEADER || out_ff.frame_status == ymr_pkg::ST_DATA, "transfer done without an accepted block")
   `ASSERT_PROP(a_verdict_at_end, clock, reset, out_valid_ff && !out_ff.frame_done |-> out_ff.frame_status == ymr_pkg::ST_NONE && !out_ff.send_ack, "verdict given before the frame end")

endmodule

`default_nettype wire

/* src/ymr_csr.sv */
// Configuration register file: holds the acknowledge byte.
`default_nettype none

module ymr_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [ymr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                    csr_pwdata,
   output logic      [31:0]                    csr_prdata,
   output logic                                csr_pready
);

   logic [7:0] ack_code_ff;
   logic [7:0] ack_code_in;
   logic       reg_index;
   logic       write_en;

   assign reg_index  = csr_paddr[2];
   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      ack_code_in = ack_code_ff;
      if (write_en && reg_index == ymr_pkg::REG_ACK_CODE) begin
         ack_code_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ack_code_ff <= ymr_pkg::ACK_RESET;
      end else begin
         ack_code_ff <= ack_code_in;
      end
   end

   assign csr_prdata = (reg_index == ymr_pkg::REG_ACK_CODE) ? {24'h000000, ack_code_ff} : 32'h0;

endmodule

`default_nettype wire

/* src/ymr_core.sv */
// Frame checker and size parser: one byte per transfer, verdict on the last byte.
`default_nettype none
`include "assert_macros.svh"

module ymr_core #(
   parameter int DATA_BLOCK_BYTES   = 1024,
   parameter int HEADER_BLOCK_BYTES = 128,
   parameter int SIZE_DIGITS        = 7
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire logic [7:0]       rx_byte,
   input  wire logic             frame_last,
   output ymr_pkg::rsp_type      result
);

   localparam int POS_W  = ymr_pkg::POS_W;
   localparam int SIZE_W = ymr_pkg::SIZE_W;
   localparam int DIG_W  = $clog2(SIZE_DIGITS + 1);

   localparam logic [POS_W-1:0]  DATA_N    = POS_W'(DATA_BLOCK_BYTES);
   localparam logic [POS_W-1:0]  HDR_N     = POS_W'(HEADER_BLOCK_BYTES);
   localparam logic [POS_W-1:0]  POS_MAX   = {POS_W{1'b1}};
   localparam logic [DIG_W-1:0]  DIG_LIMIT = DIG_W'(SIZE_DIGITS);
   localparam logic [SIZE_W:0]   DATA_ADD  = (SIZE_W + 1)'(DATA_BLOCK_BYTES);
   localparam logic [SIZE_W-1:0] TOTAL_MAX = {SIZE_W{1'b1}};

   ymr_pkg::phase_type phase_ff, phase_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [15:0]        crc_ff, crc_in, crc_base;
   logic [7:0]         kind_ff, kind_in;
   logic [7:0]         blk_seen_ff, blk_seen_in;
   logic [7:0]         exp_blk_ff, exp_blk_in;
   logic               ferr_ff, ferr_in;
   logic [2:0]         cancel_ff, cancel_in, cancel_base;
   logic [15:0]        last2_ff, last2_in;
   logic [1:0]         name_ff, name_in;
   logic [DIG_W-1:0]   digits_ff, digits_in;
   logic [SIZE_W-1:0]  scratch_ff, scratch_in, scratch_base;
   logic [SIZE_W-1:0]  size_ff, size_in;
   logic [SIZE_W-1:0]  total_ff, total_in;

   logic               hdr;
   logic               start;
   logic               in_body;
   logic               is_digit;
   logic [POS_W-1:0]   blk_n;
   logic               payload;
   logic               frame_ok;
   logic [SIZE_W:0]    total_sum;
   logic [SIZE_W-1:0]  total_sat;
   logic               is_cancel;
   logic               accept_hdr;
   logic               accept_data;
   logic               size_reached;

   // Per-byte parsing: fields that restart at the first byte of a frame take
   // their base values here so the update below sees a fresh frame.
   always_comb begin
      hdr          = (phase_ff == ymr_pkg::PH_HEADER);
      blk_n        = hdr ? HDR_N : DATA_N;
      start        = (pos_ff == '0);
      kind_in      = start ? rx_byte : kind_ff;
      crc_base     = start ? 16'h0 : crc_ff;
      cancel_base  = start ? 3'd0 : cancel_ff;
      scratch_base = start ? '0 : scratch_ff;
      name_in      = start ? ymr_pkg::NAME_IN_NAME : name_ff;
      digits_in    = start ? '0 : digits_ff;
      ferr_in      = start ? (rx_byte != (hdr ? ymr_pkg::SOH_CODE : ymr_pkg::STX_CODE))
                           : ferr_ff;

      cancel_in = cancel_base;
      if (pos_ff < POS_W'(5) && rx_byte == ymr_pkg::CAN_CODE &&
          POS_W'(cancel_base) == pos_ff) begin
         cancel_in = cancel_base + 3'd1;
      end

      blk_seen_in = blk_seen_ff;
      if (pos_ff == POS_W'(1)) begin
         blk_seen_in = rx_byte;
         if (rx_byte != (hdr ? 8'h00 : exp_blk_ff)) begin
            ferr_in = 1'b1;
         end
      end
      if (pos_ff == POS_W'(2) && rx_byte != ~blk_seen_ff) begin
         ferr_in = 1'b1;
      end

      in_body    = (pos_ff >= POS_W'(3)) && (pos_ff < blk_n + POS_W'(3));
      crc_in     = in_body ? ymr_pkg::crc_step(crc_base, rx_byte) : crc_base;
      is_digit   = (rx_byte >= ymr_pkg::DIGIT_LO) && (rx_byte <= ymr_pkg::DIGIT_HI);
      scratch_in = scratch_base;
      if (in_body && hdr) begin
         case (name_in)
            ymr_pkg::NAME_IN_NAME: begin
               if (rx_byte == 8'h00) begin
                  name_in = ymr_pkg::NAME_IN_SIZE;
               end
            end
            ymr_pkg::NAME_IN_SIZE: begin
               if (is_digit && digits_in < DIG_LIMIT) begin
                  scratch_in = (scratch_base << 3) + (scratch_base << 1) +
                               SIZE_W'(rx_byte - ymr_pkg::DIGIT_LO);
                  digits_in  = digits_in + DIG_W'(1);
               end else begin
                  name_in = ymr_pkg::NAME_DONE;
               end
            end
            default: begin
               name_in = name_in;
            end
         endcase
      end

      last2_in = {last2_ff[7:0], rx_byte};
      payload  = in_body && !hdr && (kind_in == ymr_pkg::STX_CODE);
   end

   // Frame verdict and the counters it moves.
   always_comb begin
      frame_ok     = !ferr_in && (pos_ff == blk_n + POS_W'(4)) && (crc_in == last2_in);
      total_sum    = {1'b0, total_ff} + DATA_ADD;
      total_sat    = total_sum[SIZE_W] ? TOTAL_MAX : total_sum[SIZE_W-1:0];
      is_cancel    = frame_last && !hdr && (cancel_in == ymr_pkg::CANCEL_RUN_LEN);
      accept_hdr   = frame_last && !is_cancel && frame_ok && hdr;
      accept_data  = frame_last && !is_cancel && frame_ok && !hdr;
      size_reached = total_sat >= size_ff;

      size_in  = accept_hdr ? scratch_in : size_ff;
      total_in = accept_hdr ? '0 : (accept_data ? total_sat : total_ff);

      exp_blk_in = exp_blk_ff;
      if (is_cancel || accept_hdr) begin
         exp_blk_in = 8'd1;
      end else if (accept_data) begin
         exp_blk_in = exp_blk_ff + 8'd1;
      end

      if (frame_last) begin
         pos_in = '0;
      end else begin
         pos_in = (pos_ff < POS_MAX) ? pos_ff + POS_W'(1) : POS_MAX;
      end
   end

   // Phase next state.
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         ymr_pkg::PH_HEADER: begin
            if (accept_hdr && scratch_in != '0) begin
               phase_in = ymr_pkg::PH_DATA;
            end
         end
         ymr_pkg::PH_DATA: begin
            if (is_cancel || (accept_data && size_reached)) begin
               phase_in = ymr_pkg::PH_HEADER;
            end
         end
         default: begin
            phase_in = ymr_pkg::PH_HEADER;
         end
      endcase
   end

   // Result of this byte.
   always_comb begin
      result.payload_valid  = payload;
      result.payload_byte   = payload ? rx_byte : 8'h00;
      result.frame_done     = frame_last;
      result.frame_status   = ymr_pkg::ST_NONE;
      result.send_ack       = 1'b0;
      result.transfer_done  = 1'b0;
      result.announced_size = size_in;
      result.received_bytes = total_in;
      if (frame_last) begin
         case (phase_ff)
            ymr_pkg::PH_HEADER: begin
               result.frame_status  = accept_hdr ? ymr_pkg::ST_HEADER : ymr_pkg::ST_REJECT;
               result.send_ack      = accept_hdr;
               result.transfer_done = accept_hdr && (scratch_in == '0);
            end
            ymr_pkg::PH_DATA: begin
               if (is_cancel) begin
                  result.frame_status = ymr_pkg::ST_CANCEL;
                  result.send_ack     = 1'b1;
               end else if (accept_data) begin
                  result.frame_status  = ymr_pkg::ST_DATA;
                  result.send_ack      = 1'b1;
                  result.transfer_done = size_reached;
               end else begin
                  result.frame_status = ymr_pkg::ST_REJECT;
               end
            end
            default: begin
               result.frame_status = ymr_pkg::ST_REJECT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= ymr_pkg::PH_HEADER;
         pos_ff      <= '0;
         crc_ff      <= 16'h0;
         kind_ff     <= 8'h00;
         blk_seen_ff <= 8'h00;
         exp_blk_ff  <= 8'd1;
         ferr_ff     <= 1'b0;
         cancel_ff   <= 3'd0;
         last2_ff    <= 16'h0;
         name_ff     <= ymr_pkg::NAME_IN_NAME;
         digits_ff   <= '0;
         scratch_ff  <= '0;
         size_ff     <= '0;
         total_ff    <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         crc_ff      <= crc_in;
         kind_ff     <= kind_in;
         blk_seen_ff <= blk_seen_in;
         exp_blk_ff  <= exp_blk_in;
         ferr_ff     <= ferr_in;
         cancel_ff   <= cancel_in;
         last2_ff    <= last2_in;
         name_ff     <= name_in;
         digits_ff   <= digits_in;
         scratch_ff  <= scratch_in;
         size_ff     <= size_in;
         total_ff    <= total_in;
      end
   end

   `ASSERT_PROP(a_cancel_restarts, clock, reset, step && is_cancel |=> phase_ff == ymr_pkg::PH_HEADER && exp_blk_ff == 8'd1, "cancelled transfer did not return to header phase")
   `ASSERT_PROP(a_frame_end_pos, clock, reset, step && frame_last |=> pos_ff == '0, "byte position not cleared after a frame end")
   `ASSERT_NEVER(a_data_needs_size, clock, reset, phase_ff == ymr_pkg::PH_DATA && size_ff == '0, "data phase entered with an empty file size")

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the YMODEM block receiver: frame stimulus, byte-level predictor.
`timescale 1ns / 1ps

localparam int HEADER_LEN = 128;
localparam int DATA_LEN = 1024;
localparam int SIZE_DIGIT_LIMIT = 7;
localparam int WATCHDOG_LIMIT = 2000;

// CRC-16/XMODEM advanced by one byte, one message bit at a time.
function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] data);
   logic [15:0] c;
   logic fb;
   c = crc_in;
   for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ data[i];
      c = {c[14:0], 1'b0} ^ (fb ? ymr_pkg::CRC_POLY : 16'h0000);
   end
   return c;
endfunction

class ymodem_frame_tracker;
   ymr_pkg::phase_type phase;
   logic [10:0] byte_pos;
   logic [15:0] crc;
   logic [7:0]  kind;
   logic [7:0]  blk_seen;
   logic [7:0]  expected_blk;
   logic        bad_frame;
   logic [2:0]  can_run;
   logic [15:0] tail;
   logic [1:0]  name_state;
   logic [2:0]  digits;
   logic [23:0] scratch;
   logic [23:0] size_val;
   logic [23:0] total;
   logic [7:0]  ack_code;
   ymr_pkg::rsp_type pending[$];
   int errors, checked, frames, headers, blocks, cancels, rejects, completions;

   function new();
      phase = ymr_pkg::PH_HEADER;
      byte_pos = '0;
      crc = '0;
      kind = '0;
      blk_seen = '0;
      expected_blk = 8'd1;
      bad_frame = 1'b0;
      can_run = '0;
      tail = '0;
      name_state = ymr_pkg::NAME_IN_NAME;
      digits = '0;
      scratch = '0;
      size_val = '0;
      total = '0;
      ack_code = ymr_pkg::ACK_RESET;
      errors = 0;
      checked = 0;
      frames = 0;
      headers = 0;
      blocks = 0;
      cancels = 0;
      rejects = 0;
      completions = 0;
   endfunction

   // Advances the receiver state by one transferred byte and queues the result it causes.
   function void take_byte(input logic [7:0] b, input logic last);
      logic hdr;
      logic good;
      int unsigned n;
      logic [10:0] pos;
      logic [24:0] sum;
      ymr_pkg::rsp_type r;
      hdr = (phase == ymr_pkg::PH_HEADER);
      n = hdr ? HEADER_LEN : DATA_LEN;
      pos = byte_pos;
      r = '0;
      if (pos == 0) begin
         kind = b;
         crc = '0;
         can_run = '0;
         name_state = ymr_pkg::NAME_IN_NAME;
         digits = '0;
         scratch = '0;
         bad_frame = (b != (hdr ? ymr_pkg::SOH_CODE : ymr_pkg::STX_CODE));
      end
      if (pos < 5 && b == ymr_pkg::CAN_CODE && can_run == pos)
         can_run++;
      if (pos == 1) begin
         blk_seen = b;
         if (b != (hdr ? 8'h00 : expected_blk))
            bad_frame = 1'b1;
      end
      if (pos == 2 && b != ~blk_seen)
         bad_frame = 1'b1;
      if (pos >= 3 && pos < 3 + n) begin
         crc = crc16_byte(crc, b);
         if (hdr) begin
            if (name_state == ymr_pkg::NAME_IN_NAME) begin
               if (b == 8'h00)
                  name_state = ymr_pkg::NAME_IN_SIZE;
            end else if (name_state == ymr_pkg::NAME_IN_SIZE) begin
               if (b >= ymr_pkg::DIGIT_LO && b <= ymr_pkg::DIGIT_HI
                   && digits < SIZE_DIGIT_LIMIT) begin
                  scratch = 24'(scratch * 10 + (b - ymr_pkg::DIGIT_LO));
                  digits++;
               end else begin
                  name_state = ymr_pkg::NAME_DONE;
               end
            end
         end else if (kind == ymr_pkg::STX_CODE) begin
            r.payload_valid = 1'b1;
         end
      end
      tail = {tail[7:0], b};

      if (last) begin
         frames++;
         good = !bad_frame && pos == n + 4 && crc == tail;
         if (!hdr && can_run == ymr_pkg::CANCEL_RUN_LEN) begin
            r.frame_status = ymr_pkg::ST_CANCEL;
            r.send_ack = 1'b1;
            phase = ymr_pkg::PH_HEADER;
            expected_blk = 8'd1;
            cancels++;
         end else if (!good) begin
            r.frame_status = ymr_pkg::ST_REJECT;
            rejects++;
         end else if (hdr) begin
            r.frame_status = ymr_pkg::ST_HEADER;
            r.send_ack = 1'b1;
            size_val = scratch;
            total = '0;
            expected_blk = 8'd1;
            headers++;
            if (size_val == 0)
               r.transfer_done = 1'b1;
            else
               phase = ymr_pkg::PH_DATA;
         end else begin
            r.frame_status = ymr_pkg::ST_DATA;
            r.send_ack = 1'b1;
            expected_blk = expected_blk + 8'd1;
            sum = 25'({1'b0, total} + DATA_LEN);
            total = sum[24] ? 24'hFFFFFF : sum[23:0];
            blocks++;
            if (total >= size_val) begin
               r.transfer_done = 1'b1;
               phase = ymr_pkg::PH_HEADER;
            end
         end
         byte_pos = '0;
      end else if (byte_pos != 11'h7FF) begin
         byte_pos = byte_pos + 11'd1;
      end

      if (r.transfer_done)
         completions++;
      r.payload_byte = r.payload_valid ? b : 8'h00;
      r.frame_done = last;
      r.announced_size = size_val;
      r.received_bytes = total;
      pending.push_back(r);
   endfunction

   function void field_check(input string label, input logic [23:0] want,
                             input logic [23:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t ns: result %0d %s expected %0d, actual %0d",
                  $time, checked, label, want, got);
      end
   endfunction

   function void match_output(input ymr_pkg::rsp_type got);
      ymr_pkg::rsp_type want;
      if (pending.size() == 0) begin
         errors++;
         $display("%0t ns: result with nothing expected, expected none, actual status %0d",
                  $time, got.frame_status);
         return;
      end
      want = pending.pop_front();
      field_check("payload_valid", want.payload_valid, got.payload_valid);
      field_check("payload_byte", want.payload_byte, got.payload_byte);
      field_check("frame_done", want.frame_done, got.frame_done);
      field_check("frame_status", want.frame_status, got.frame_status);
      field_check("send_ack", want.send_ack, got.send_ack);
      field_check("transfer_done", want.transfer_done, got.transfer_done);
      field_check("announced_size", want.announced_size, got.announced_size);
      field_check("received_bytes", want.received_bytes, got.received_bytes);
      checked++;
   endfunction
endclass

module tb;
   localparam logic [ymr_pkg::CSR_ADDR_W-1:0] ACK_ADDR =
      ymr_pkg::CSR_ADDR_W'(4 * int'(ymr_pkg::REG_ACK_CODE));

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic req_frame_last = 1'b0;

   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_payload_valid;
   logic [7:0] rsp_payload_byte;
   logic rsp_frame_done;
   logic [2:0] rsp_frame_status;
   logic rsp_send_ack;
   logic rsp_transfer_done;
   logic [ymr_pkg::SIZE_W-1:0] rsp_announced_size;
   logic [ymr_pkg::SIZE_W-1:0] rsp_received_bytes;

   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [ymr_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   ymodem_frame_tracker trk;
   ymr_pkg::rsp_type seen_rsp;
   logic [7:0] frame[$];
   bit quiet = 1'b0;
   bit send_idling = 1'b1;
   int send_mode_left = 100;
   bit stall_mode = 1'b1;
   int stall_mode_left = 150;
   int stall_left = 0;
   int bytes_sent = 0;
   int ack_writes = 0;
   int idle_cycles = 0;
   int quiet_start = 0;
   int pick;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   ymodem_block_receiver dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .req_frame_last(req_frame_last),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload_valid(rsp_payload_valid),
      .rsp_payload_byte(rsp_payload_byte),
      .rsp_frame_done(rsp_frame_done),
      .rsp_frame_status(rsp_frame_status),
      .rsp_send_ack(rsp_send_ack),
      .rsp_transfer_done(rsp_transfer_done),
      .rsp_announced_size(rsp_announced_size),
      .rsp_received_bytes(rsp_received_bytes),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Result side: check each transfer, then decide the stall for the next cycle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen_rsp.payload_valid = rsp_payload_valid;
            seen_rsp.payload_byte = rsp_payload_byte;
            seen_rsp.frame_done = rsp_frame_done;
            seen_rsp.frame_status = rsp_frame_status;
            seen_rsp.send_ack = rsp_send_ack;
            seen_rsp.transfer_done = rsp_transfer_done;
            seen_rsp.announced_size = rsp_announced_size;
            seen_rsp.received_bytes = rsp_received_bytes;
            trk.match_output(seen_rsp);
         end
         if (quiet)
            stall_left = 0;
         else if (stall_left == 0 && stall_mode && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 15);
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
         stall_mode_left--;
         if (stall_mode_left <= 0) begin
            stall_mode = !stall_mode;
            stall_mode_left = $urandom_range(50, 300);
         end
      end
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, trk.pending.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Holds the input side until every transferred byte has produced its result.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (trk.pending.size() != 0);
   endtask

   task automatic csr_write(input logic [7:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ACK_ADDR;
      csr_pwdata <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      trk.ack_code = value;
      ack_writes++;
   endtask

   task automatic csr_read_check();
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= ACK_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[7:0] !== trk.ack_code) begin
         trk.errors++;
         $display("%0t ns: ack_code read expected %0d, actual %0d",
                  $time, trk.ack_code, csr_prdata[7:0]);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic push_byte(input logic [7:0] b, input logic last);
      int gap;
      if (!quiet && $urandom_range(0, 499) == 0)
         wait_drained();
      gap = (!quiet && send_idling && $urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      req_frame_last <= last;
      do @(posedge clock); while (req_stall);
      trk.take_byte(b, last);
      bytes_sent++;
      send_mode_left--;
      if (send_mode_left <= 0) begin
         send_idling = !send_idling;
         send_mode_left = $urandom_range(40, 200);
      end
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame.size(); i++)
         push_byte(frame[i], i == frame.size() - 1);
   endtask

   // Header block: a name, its NUL, the decimal size, a terminator and filler, or random bytes with no NUL.
   function automatic void make_header();
      logic [7:0] body[$];
      logic [7:0] dec[$];
      logic [15:0] c;
      int kind_pick, zeros;
      int unsigned v;
      kind_pick = $urandom_range(0, 99);
      if (kind_pick < 4) begin
         // No NUL anywhere, so no size field is ever found.
         repeat (HEADER_LEN) body.push_back(8'($urandom_range(1, 255)));
      end else begin
         repeat ($urandom_range(0, 24)) body.push_back(8'($urandom_range(1, 255)));
         body.push_back(8'h00);
         if (kind_pick < 14)
            v = 0;
         else if (kind_pick < 80)
            v = $urandom_range(1, 3 * DATA_LEN);
         else if (kind_pick < 90)
            v = $urandom_range(1, DATA_LEN);
         else if (kind_pick < 96)
            v = $urandom_range(3 * DATA_LEN + 1, 9999999);
         else
            v = 9999999;
         while (v != 0) begin
            dec.push_front(8'(ymr_pkg::DIGIT_LO + v % 10));
            v = v / 10;
         end
         // Leading zeros can push the field past the digit limit.
         if (kind_pick >= 80 && kind_pick < 90)
            zeros = $urandom_range(1, 6);
         else
            zeros = (kind_pick < 14) ? $urandom_range(0, 2) : 0;
         repeat (zeros) dec.push_front(ymr_pkg::DIGIT_LO);
         foreach (dec[i]) body.push_back(dec[i]);
         body.push_back(kind_pick[0] ? 8'h00 : 8'h20);
         while (body.size() < HEADER_LEN) body.push_back(8'($urandom));
      end
      frame.delete();
      frame.push_back(ymr_pkg::SOH_CODE);
      frame.push_back(8'h00);
      frame.push_back(8'hFF);
      c = 16'h0000;
      foreach (body[i]) begin
         frame.push_back(body[i]);
         c = crc16_byte(c, body[i]);
      end
      frame.push_back(c[15:8]);
      frame.push_back(c[7:0]);
   endfunction

   function automatic void make_block(input logic [7:0] blk);
      logic [7:0] d;
      logic [15:0] c;
      frame.delete();
      frame.push_back(ymr_pkg::STX_CODE);
      frame.push_back(blk);
      frame.push_back(~blk);
      c = 16'h0000;
      repeat (DATA_LEN) begin
         d = 8'($urandom);
         frame.push_back(d);
         c = crc16_byte(c, d);
      end
      frame.push_back(c[15:8]);
      frame.push_back(c[7:0]);
   endfunction

   // Short junk frame, often opening with a run of cancel bytes.
   function automatic void make_noise();
      int len, cans;
      len = $urandom_range(1, 8);
      cans = $urandom_range(0, 5);
      frame.delete();
      for (int i = 0; i < len; i++)
         frame.push_back(i < cans ? ymr_pkg::CAN_CODE : 8'($urandom));
   endfunction

   function automatic void make_cancel();
      frame.delete();
      repeat (5) frame.push_back(ymr_pkg::CAN_CODE);
      repeat ($urandom_range(0, 3)) frame.push_back(8'($urandom));
   endfunction

   function automatic void damage();
      int how, idx;
      how = $urandom_range(0, 39);
      if (how < 20) begin
         idx = $urandom_range(0, frame.size() - 1);
         frame[idx] = frame[idx] ^ 8'($urandom_range(1, 255));
      end else if (how < 29) begin
         void'(frame.pop_back());
      end else if (how < 38) begin
         frame.insert($urandom_range(3, frame.size() - 1), 8'($urandom));
      end else begin
         // Long enough to saturate the byte position.
         while (frame.size() < 2060) frame.push_back(8'($urandom));
      end
   endfunction

   initial begin
      trk = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      csr_read_check();
      csr_write(8'hFF);
      csr_read_check();

      // Short frames in the header phase: byte extremes, a cancel run, bad
      // length, bad complement and the wrong start byte are all rejected.
      frame = '{8'h00};
      send_frame();
      frame = '{8'hFF};
      send_frame();
      make_cancel();
      void'(frame.pop_back());
      while (frame.size() > 5) void'(frame.pop_back());
      send_frame();
      frame = '{ymr_pkg::SOH_CODE, 8'h00, 8'hFF};
      send_frame();
      frame = '{ymr_pkg::SOH_CODE, 8'h00, 8'h00, 8'hA5};
      send_frame();
      frame = '{ymr_pkg::STX_CODE, 8'h01, 8'hFE, 8'h00, 8'hFF};
      send_frame();

      wait_drained();
      csr_write(8'h00);
      csr_read_check();

      forever begin
         if (!quiet && bytes_sent >= 700) begin
            quiet = 1'b1;
            quiet_start = bytes_sent;
         end
         if (quiet && bytes_sent >= quiet_start + 250)
            break;
         pick = $urandom_range(0, 99);
         if (trk.phase == ymr_pkg::PH_HEADER) begin
            if (pick < 65) begin
               make_header();
            end else if (pick < 80) begin
               make_header();
               damage();
            end else begin
               make_noise();
            end
         end else begin
            if (pick < 72) begin
               make_block(trk.expected_blk);
            end else if (pick < 77) begin
               make_block(trk.expected_blk - 8'd1);
            end else if (pick < 83) begin
               make_block(trk.expected_blk);
               damage();
            end else if (pick < 93) begin
               make_cancel();
            end else begin
               make_noise();
            end
         end
         send_frame();
         if (!quiet && $urandom_range(0, 29) == 0) begin
            wait_drained();
            pick = $urandom_range(0, 2);
            csr_write(pick == 0 ? 8'h00 : (pick == 1 ? 8'hFF : 8'($urandom)));
            csr_read_check();
         end
      end

      req_valid <= 1'b0;
      while (trk.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("Sent %0d bytes in %0d frames: %0d headers and %0d data blocks acknowledged,",
               bytes_sent, trk.frames, trk.headers, trk.blocks);
      $display("%0d cancels, %0d rejects, %0d completed transfers, %0d ack_code writes.",
               trk.cancels, trk.rejects, trk.completions, ack_writes);
      if (trk.errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
